@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/bbd_pkg.sv @@
// Shared constants and types of the binarizing box downscaler.
package bbd_pkg;

  localparam int OUT_SIDE_DEF = 28;
  localparam int MAX_SIDE_DEF = 4096;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int SIZE_W      = 13;
  localparam int MODE_W      = 2;
  localparam int CH_W        = 8;
  localparam int VALUE_W     = 9;

  localparam int SIZE_RESET  = 28;
  localparam int DARK_LIMIT  = 128;
  localparam int VALUE_FULL  = 256;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MODE   = 2'd2
  } reg_index_t;

  localparam logic [MODE_W-1:0] MODE_RGB  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RGBA = 2'd1;

  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [MODE_W-1:0] mode;
    logic              restart;
  } cfg_t;

endpackage

@@ hw/rtl/bbd_fifo.sv @@
// Small register queue between the front and the back end.
module bbd_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  logic [DATA_W-1:0] wr_data,
  output logic              full,
  input  logic              rd,
  output logic [DATA_W-1:0] rd_data,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_wr;
  logic              do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (do_wr && !do_rd) begin
        count <= CNT_W'(count + 1'b1);
      end else if (do_rd && !do_wr) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ hw/rtl/bbd_front.sv @@
// Front end: binarizes pixels, tracks position, accumulates cell sums, drains bands.
module bbd_front #(
  parameter  int OUT_SIDE = bbd_pkg::OUT_SIDE_DEF,
  parameter  int MAX_SIDE = bbd_pkg::MAX_SIDE_DEF,
  localparam int IDX_W    = $clog2(OUT_SIDE),
  localparam int BAND_W   = $clog2(MAX_SIDE / OUT_SIDE + 2),
  localparam int CNT_W    = 2 * BAND_W,
  localparam int ITEM_W   = 2 * IDX_W + 1 + 2 * CNT_W
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bbd_pkg::cfg_t             cfg,
  input  logic                      push,
  output logic                      full,
  input  logic [bbd_pkg::CH_W-1:0]  red,
  input  logic [bbd_pkg::CH_W-1:0]  green,
  input  logic [bbd_pkg::CH_W-1:0]  blue,
  input  logic [bbd_pkg::CH_W-1:0]  alpha,
  input  logic                      q_full,
  output logic                      q_push,
  output logic [ITEM_W-1:0]         q_data
);

  import bbd_pkg::*;

  localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
  localparam int SUM3_W     = CH_W + 2;
  localparam int PROD_W     = SUM3_W + CH_W;
  localparam int DIV3_SHIFT = PROD_W + 1;
  localparam int DIV3_RECIP = (2 ** DIV3_SHIFT + 2) / 3;
  localparam int RECIP_W    = DIV3_SHIFT;

  typedef enum logic [1:0] {S_PIX, S_WR, S_DRD, S_DPUSH} state_t;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIZE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    if (int'(v) < OUT_SIDE) begin
      r = SIDE_W'(OUT_SIDE);
    end else if (int'(v) > MAX_SIDE) begin
      r = SIDE_W'(MAX_SIDE);
    end else begin
      r = SIDE_W'(v);
    end
    return r;
  endfunction

  state_t            state;
  logic [SIDE_W-1:0] scol;
  logic [SIDE_W-1:0] srow;
  logic [SIDE_W-1:0] dcol;
  logic [SIDE_W-1:0] drow;
  logic [IDX_W-1:0]  col_band;
  logic [IDX_W-1:0]  row_band;
  logic [BAND_W-1:0] ccnt;
  logic [BAND_W-1:0] rows_in_band;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  drain_idx;
  logic              go_drain;
  logic [SUM3_W-1:0] s_q;
  logic [PROD_W-1:0] p_q;

  logic [CNT_W-1:0]  sums_mem [OUT_SIDE];
  logic [BAND_W-1:0] colw_mem [OUT_SIDE];
  logic [OUT_SIDE-1:0] sum_vld;
  logic [CNT_W-1:0]  sum_rd;
  logic [BAND_W-1:0] colw_rd;

  logic [SIDE_W-1:0] w_side;
  logic [SIDE_W-1:0] h_side;
  logic [SIDE_W-1:0] dc;
  logic [SIDE_W-1:0] dr;
  logic [SIDE_W-1:0] dcol_next;
  logic [SIDE_W-1:0] drow_next;
  logic              col_inc;
  logic              band_end;
  logic              row_end;
  logic              frame_end;
  logic              accept;
  logic [SUM3_W-1:0] s_next;
  logic [PROD_W-1:0] p_next;
  logic [PROD_W+RECIP_W-1:0] q3;
  logic              dark;
  logic [CNT_W-1:0]  new_sum;
  logic [CNT_W-1:0]  drain_sum;
  logic [CNT_W-1:0]  drain_cnt;
  logic              drain_last;

  assign w_side = clamp_side(cfg.width);
  assign h_side = clamp_side(cfg.height);
  assign full   = (state != S_PIX);
  assign accept = push && (state == S_PIX);

  // Distance to the next band edge; at the start of a row or frame it is size - OUT_SIDE.
  assign dc        = (scol == '0) ? SIDE_W'(w_side - SIDE_W'(OUT_SIDE)) : dcol;
  assign col_inc   = (dc < SIDE_W'(OUT_SIDE));
  assign dcol_next = SIDE_W'((SIDE_W+1)'(dc) + (col_inc ? (SIDE_W+1)'(w_side) : '0)
                             - (SIDE_W+1)'(OUT_SIDE));
  assign row_end   = (SIDE_W'(scol + 1'b1) == w_side);

  assign dr        = (srow == '0) ? SIDE_W'(h_side - SIDE_W'(OUT_SIDE)) : drow;
  assign band_end  = (dr < SIDE_W'(OUT_SIDE));
  assign drow_next = SIDE_W'((SIDE_W+1)'(dr) + (band_end ? (SIDE_W+1)'(h_side) : '0)
                             - (SIDE_W+1)'(OUT_SIDE));
  assign frame_end = (SIDE_W'(srow + 1'b1) == h_side);

  assign s_next = SUM3_W'(red) + SUM3_W'(green) + SUM3_W'(blue);
  assign p_next = PROD_W'(s_next) * PROD_W'(alpha);

  // Divide by three through the reciprocal; only bit 7 of the quotient matters.
  assign q3 = (PROD_W+RECIP_W)'(p_q) * (PROD_W+RECIP_W)'(DIV3_RECIP);

  always_comb begin
    case (cfg.mode)
      MODE_RGB:  dark = (s_q < SUM3_W'(3 * DARK_LIMIT));
      MODE_RGBA: dark = !q3[DIV3_SHIFT + CH_W - 1];
      default:   dark = 1'b0;
    endcase
  end

  assign new_sum = (sum_vld[wr_addr] ? sum_rd : '0) + CNT_W'(dark);

  assign drain_sum  = sum_vld[drain_idx] ? sum_rd : '0;
  assign drain_cnt  = CNT_W'(colw_rd * rows_in_band);
  assign drain_last = (drain_idx == IDX_W'(OUT_SIDE - 1));
  assign q_push     = (state == S_DPUSH) && !q_full;
  assign q_data     = {row_band, drain_idx, drain_last, drain_sum, drain_cnt};

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      state        <= S_PIX;
      scol         <= '0;
      srow         <= '0;
      col_band     <= '0;
      row_band     <= '0;
      ccnt         <= '0;
      rows_in_band <= '0;
      go_drain     <= 1'b0;
      sum_vld      <= '0;
    end else begin
      case (state)
        S_PIX: begin
          if (push) begin
            s_q     <= s_next;
            p_q     <= p_next;
            wr_addr <= col_band;
            dcol    <= dcol_next;
            ccnt    <= col_inc ? '0 : BAND_W'(ccnt + 1'b1);
            go_drain <= row_end && band_end;
            if (row_end) begin
              scol         <= '0;
              col_band     <= '0;
              rows_in_band <= BAND_W'(rows_in_band + 1'b1);
              srow         <= frame_end ? '0 : SIDE_W'(srow + 1'b1);
              drow         <= drow_next;
            end else begin
              scol     <= SIDE_W'(scol + 1'b1);
              col_band <= col_inc ? IDX_W'(col_band + 1'b1) : col_band;
            end
            state <= S_WR;
          end
        end
        S_WR: begin
          sum_vld[wr_addr] <= 1'b1;
          drain_idx        <= '0;
          state            <= go_drain ? S_DRD : S_PIX;
        end
        S_DRD: begin
          state <= S_DPUSH;
        end
        S_DPUSH: begin
          if (!q_full) begin
            // Hand the cell to the back end and clear it for the next band.
            sum_vld[drain_idx] <= 1'b0;
            if (drain_last) begin
              rows_in_band <= '0;
              row_band     <= (srow == '0) ? '0 : IDX_W'(row_band + 1'b1);
              state        <= S_PIX;
            end else begin
              drain_idx <= IDX_W'(drain_idx + 1'b1);
              state     <= S_DRD;
            end
          end
        end
        default: state <= S_PIX;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sum_rd <= sums_mem[col_band];
      if (col_inc) begin
        colw_mem[col_band] <= BAND_W'(ccnt + 1'b1);
      end
    end
    if (state == S_DRD) begin
      sum_rd  <= sums_mem[drain_idx];
      colw_rd <= colw_mem[drain_idx];
    end
    if (state == S_WR) begin
      sums_mem[wr_addr] <= new_sum;
    end
  end

endmodule

@@ hw/rtl/bbd_back.sv @@
// Back end: serial divider for cell averages and the result register.
module bbd_back #(
  parameter  int OUT_SIDE = bbd_pkg::OUT_SIDE_DEF,
  parameter  int MAX_SIDE = bbd_pkg::MAX_SIDE_DEF,
  localparam int IDX_W    = $clog2(OUT_SIDE),
  localparam int BAND_W   = $clog2(MAX_SIDE / OUT_SIDE + 2),
  localparam int CNT_W    = 2 * BAND_W,
  localparam int ITEM_W   = 2 * IDX_W + 1 + 2 * CNT_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  logic [ITEM_W-1:0]           q_data,
  input  logic                        pop,
  output logic                        empty,
  output logic [IDX_W-1:0]            cell_row,
  output logic [IDX_W-1:0]            cell_col,
  output logic [bbd_pkg::VALUE_W-1:0] cell_value,
  output logic                        last_of_band
);

  import bbd_pkg::*;

  localparam int STEP_W    = $clog2(VALUE_W);
  localparam int LAST_STEP = VALUE_W - 1;

  logic                busy;
  logic [STEP_W-1:0]   step;
  logic [CNT_W:0]      rem;
  logic [CNT_W-1:0]    den;
  logic [VALUE_W-1:0]  quot;
  logic [IDX_W-1:0]    row_q;
  logic [IDX_W-1:0]    col_q;
  logic                last_q;
  logic                out_valid;

  logic [IDX_W-1:0]    in_row;
  logic [IDX_W-1:0]    in_col;
  logic                in_last;
  logic [CNT_W-1:0]    in_sum;
  logic [CNT_W-1:0]    in_cnt;
  logic [CNT_W:0]      trial;
  logic                qbit;
  logic [CNT_W:0]      rem_next;
  logic [VALUE_W-1:0]  quot_next;
  logic                final_step;
  logic                can_take;

  assign {in_row, in_col, in_last, in_sum, in_cnt} = q_data;

  assign q_pop = !busy && !q_empty;
  assign empty = !out_valid;

  // The first step compares the sum itself; the sum never exceeds the count.
  assign trial      = (step == '0) ? rem : {rem[CNT_W-1:0], 1'b0};
  assign qbit       = (trial >= (CNT_W+1)'(den));
  assign rem_next   = qbit ? (CNT_W+1)'(trial - (CNT_W+1)'(den)) : trial;
  assign quot_next  = {quot[VALUE_W-2:0], qbit};
  assign final_step = busy && (step == STEP_W'(LAST_STEP));
  assign can_take   = !out_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        busy   <= 1'b1;
        step   <= '0;
        rem    <= (CNT_W+1)'(in_sum);
        den    <= in_cnt;
        quot   <= '0;
        row_q  <= in_row;
        col_q  <= in_col;
        last_q <= in_last;
      end else if (busy && (!final_step || can_take)) begin
        rem  <= rem_next;
        quot <= quot_next;
        step <= STEP_W'(step + 1'b1);
        if (final_step) begin
          busy         <= 1'b0;
          out_valid    <= 1'b1;
          cell_value   <= quot_next;
          cell_row     <= row_q;
          cell_col     <= col_q;
          last_of_band <= last_q;
        end
      end
    end
  end

endmodule

@@ hw/rtl/binarize_box_downscale.sv @@
// Pixel input takes a new pixel only while the front is in its pixel state; full is high in the
// cycle after each accepted push, and a band end holds it high while its 28 cells go to the
// queue, paced by the back end once the queue is full.
// Each cell average is a 9-step serial division; the back end takes no new cell while one is
// in division, and its last step waits until the previous result has been taken.
// rst (synchronous) restores 28x28 rgb; it and any listed register write restart the frame.
module binarize_box_downscale #(
  parameter  int OUT_SIDE = bbd_pkg::OUT_SIDE_DEF,
  parameter  int MAX_SIDE = bbd_pkg::MAX_SIDE_DEF,
  localparam int IDX_W    = $clog2(OUT_SIDE)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [bbd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bbd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            push,
  output logic                            full,
  input  logic [bbd_pkg::CH_W-1:0]        red,
  input  logic [bbd_pkg::CH_W-1:0]        green,
  input  logic [bbd_pkg::CH_W-1:0]        blue,
  input  logic [bbd_pkg::CH_W-1:0]        alpha,
  input  logic                            pop,
  output logic                            empty,
  output logic [IDX_W-1:0]                cell_row,
  output logic [IDX_W-1:0]                cell_col,
  output logic [bbd_pkg::VALUE_W-1:0]     cell_value,
  output logic                            last_of_band
);

  import bbd_pkg::*;

  localparam int BAND_W  = $clog2(MAX_SIDE / OUT_SIDE + 2);
  localparam int CNT_W   = 2 * BAND_W;
  localparam int ITEM_W  = 2 * IDX_W + 1 + 2 * CNT_W;
  localparam int Q_DEPTH = 4;

  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  logic [MODE_W-1:0] mode_reg;
  cfg_t              cfg;

  logic              q_push;
  logic              q_full;
  logic [ITEM_W-1:0] q_wdata;
  logic              q_pop;
  logic              q_empty;
  logic [ITEM_W-1:0] q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= SIZE_W'(SIZE_RESET);
      height_reg <= SIZE_W'(SIZE_RESET);
      mode_reg   <= MODE_RGB;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WIDTH:  width_reg  <= SIZE_W'(cfg_data);
        REG_HEIGHT: height_reg <= SIZE_W'(cfg_data);
        REG_MODE:   mode_reg   <= MODE_W'(cfg_data);
        default:    ;
      endcase
    end
  end

  assign cfg.width   = width_reg;
  assign cfg.height  = height_reg;
  assign cfg.mode    = mode_reg;
  assign cfg.restart = cfg_write && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
                                     cfg_index == REG_MODE);

  bbd_front #(
    .OUT_SIDE (OUT_SIDE),
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .push   (push),
    .full   (full),
    .red    (red),
    .green  (green),
    .blue   (blue),
    .alpha  (alpha),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  bbd_fifo #(
    .DATA_W (ITEM_W),
    .DEPTH  (Q_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd      (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  bbd_back #(
    .OUT_SIDE (OUT_SIDE),
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_data       (q_rdata),
    .pop          (pop),
    .empty        (empty),
    .cell_row     (cell_row),
    .cell_col     (cell_col),
    .cell_value   (cell_value),
    .last_of_band (last_of_band)
  );

endmodule

@@ hw/rtl/bbd_checker.sv @@
// Port-level checks of the downscaler, bound to the top level.
`include "assert_macros.svh"

module bbd_checker #(
  parameter  int OUT_SIDE = bbd_pkg::OUT_SIDE_DEF,
  localparam int IDX_W    = $clog2(OUT_SIDE)
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        cfg_write,
  input logic                        push,
  input logic                        full,
  input logic                        pop,
  input logic                        empty,
  input logic [IDX_W-1:0]            cell_col,
  input logic [bbd_pkg::VALUE_W-1:0] cell_value,
  input logic                        last_of_band
);

  import bbd_pkg::*;

  // A cell average never exceeds a fully dark cell.
  `BBD_ASSERT_NOW(a_value_range, clk, rst, !empty, int'(cell_value) <= VALUE_FULL)

  // The band marker sits on the rightmost cell and nowhere else.
  `BBD_ASSERT_NOW(a_last_col, clk, rst, !empty, last_of_band == (int'(cell_col) == OUT_SIDE - 1))

  // An accepted pixel transaction with no register write alongside is followed by full high.
  `BBD_ASSERT_NEXT(a_pixel_busy, clk, rst, push && !full && !cfg_write, full)

  // Hold a waiting result until it is taken.
  `BBD_ASSERT_NEXT(a_result_hold, clk, rst, !empty && !pop,
                   !empty && $stable(cell_value) && $stable(cell_col))

endmodule

bind binarize_box_downscale bbd_checker #(.OUT_SIDE(OUT_SIDE)) u_bbd_checker (.*);

@@ dv/tb_top.sv @@
// Testbench for binarize_box_downscale: queue-driven pixel source, cell checker and predictor.
module tb_top;
  import bbd_pkg::*;

  localparam int OUT_SIDE = OUT_SIDE_DEF;
  localparam int MAX_SIDE = MAX_SIDE_DEF;
  localparam int IDX_W    = $clog2(OUT_SIDE);
  localparam int CHANNELS = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE  = 2'd3;
  localparam logic [MODE_W-1:0]      MODE_ZERO  = 2'd2;
  localparam logic [MODE_W-1:0]      MODE_SPARE = 2'd3;

  localparam int LONG_HOLD     = 600;
  localparam int SETTLE_CYCLES = 64;
  localparam int TAIL_CYCLES   = 400;
  localparam int TIMEOUT       = 4_000_000;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [VALUE_W-1:0] value;
    logic               last;
  } cell_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   push = 1'b0;
  logic                   full;
  logic [CH_W-1:0]        red = '0;
  logic [CH_W-1:0]        green = '0;
  logic [CH_W-1:0]        blue = '0;
  logic [CH_W-1:0]        alpha = '0;
  logic                   pop = 1'b0;
  logic                   empty;
  logic [IDX_W-1:0]       cell_row;
  logic [IDX_W-1:0]       cell_col;
  logic [VALUE_W-1:0]     cell_value;
  logic                   last_of_band;

  binarize_box_downscale u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .pop          (pop),
    .empty        (empty),
    .cell_row     (cell_row),
    .cell_col     (cell_col),
    .cell_value   (cell_value),
    .last_of_band (last_of_band)
  );

  always #2 clk = ~clk;

  pixel_t       pixels_pending[$];
  cell_result_t cells_due[$];
  int unsigned  mismatches = 0;

  // predictor state
  logic [SIZE_W-1:0] img_w;
  logic [SIZE_W-1:0] img_h;
  logic [MODE_W-1:0] img_mode;
  int unsigned       cell_sum[OUT_SIDE];
  int unsigned       src_col, src_row, col_band, row_band, band_rows;

  logic        pix_taken = 1'b0;
  logic        cell_taken = 1'b0;
  pixel_t      next_pix;
  int unsigned src_gap = 0, src_burst = 0;
  int unsigned snk_gap = 0, snk_burst = 0;
  bit          hold_request = 1'b0;
  bit          hold_served = 1'b0;
  int unsigned hold_count = 0;

  function automatic int unsigned clamp_side(logic [SIZE_W-1:0] v);
    if (v < OUT_SIDE) return OUT_SIDE;
    if (v > MAX_SIDE) return MAX_SIDE;
    return v;
  endfunction

  function automatic int unsigned band_edge(int unsigned k, int unsigned size);
    return k * size / OUT_SIDE;
  endfunction

  function automatic logic is_dark(pixel_t p);
    int unsigned sum;
    int unsigned level;
    sum = p.red;
    sum += p.green;
    sum += p.blue;
    if (img_mode == MODE_RGB) begin
      level = sum / CHANNELS;
    end else if (img_mode == MODE_RGBA) begin
      // keep only the low byte of the weighted mean
      level = ((sum * p.alpha) / CHANNELS) % (1 << CH_W);
    end else begin
      return 1'b0;
    end
    return level < DARK_LIMIT;
  endfunction

  function automatic void restart_frame();
    foreach (cell_sum[i]) cell_sum[i] = 0;
    src_col = 0;
    src_row = 0;
    col_band = 0;
    row_band = 0;
    band_rows = 0;
  endfunction

  function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_WIDTH: img_w = val;
      REG_HEIGHT: img_h = val;
      REG_MODE: img_mode = val[MODE_W-1:0];
      default: return;
    endcase
    restart_frame();
  endfunction

  function automatic void accumulate_pixel(pixel_t p);
    int unsigned  w, h, c, cols, count, avg;
    cell_result_t res;
    w = clamp_side(img_w);
    h = clamp_side(img_h);
    if (col_band >= OUT_SIDE || src_col >= w || src_row >= h || row_band >= OUT_SIDE)
      restart_frame();
    cell_sum[col_band] += is_dark(p);
    if (src_col + 1 == band_edge(col_band + 1, w)) col_band++;
    src_col++;
    if (src_col < w) return;

    src_col = 0;
    col_band = 0;
    band_rows++;
    src_row++;
    if (src_row == band_edge(row_band + 1, h)) begin
      for (c = 0; c < OUT_SIDE; c++) begin
        cols = band_edge(c + 1, w) - band_edge(c, w);
        count = cols * band_rows;
        avg = (count != 0) ? cell_sum[c] * VALUE_FULL / count : 0;
        res.row = row_band[IDX_W-1:0];
        res.col = c[IDX_W-1:0];
        res.value = avg[VALUE_W-1:0];
        res.last = (c == OUT_SIDE - 1);
        cells_due.push_back(res);
        cell_sum[c] = 0;
      end
      band_rows = 0;
      row_band++;
    end
    // wrap to a new frame after the last row
    if (src_row >= h) begin
      src_row = 0;
      row_band = 0;
      band_rows = 0;
    end
  endfunction

  function automatic void compare_field(string name, logic [VALUE_W-1:0] want,
                                        logic [VALUE_W-1:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_cell();
    cell_result_t want;
    if (cells_due.size() == 0) begin
      $display("%0t unexpected cell: expected none, actual row %0d col %0d value %0d last %0d",
               $time, cell_row, cell_col, cell_value, last_of_band);
      mismatches++;
      return;
    end
    want = cells_due.pop_front();
    compare_field("cell_row", want.row, cell_row);
    compare_field("cell_col", want.col, cell_col);
    compare_field("cell_value", want.value, cell_value);
    compare_field("last_of_band", want.last, last_of_band);
  endfunction

  function automatic int unsigned next_gap(inout int unsigned burst);
    int unsigned roll;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(4, 16);
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t      p;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    p = $urandom;
    if (pick < 15) begin
      p.red = $urandom_range(0, 1) ? '1 : '0;
      p.green = $urandom_range(0, 1) ? '1 : '0;
      p.blue = $urandom_range(0, 1) ? '1 : '0;
      p.alpha = $urandom_range(0, 1) ? '1 : '0;
    end else if (pick < 45) begin
      // channel mean close to the dark limit
      p.red = $urandom_range(120, 136);
      p.green = $urandom_range(120, 136);
      p.blue = $urandom_range(120, 136);
    end
    return p;
  endfunction

  // transaction tracking, prediction and checking
  always @(posedge clk) begin
    if (rst) begin
      pix_taken <= 1'b0;
      cell_taken <= 1'b0;
      img_w = SIZE_W'(SIZE_RESET);
      img_h = SIZE_W'(SIZE_RESET);
      img_mode = MODE_RGB;
      restart_frame();
    end else begin
      pix_taken <= push && !full;
      cell_taken <= pop && !empty;
      if (cfg_write) apply_reg(cfg_index, cfg_data);
      if (push && !full) accumulate_pixel({red, green, blue, alpha});
      if (pop && !empty) check_cell();
    end
  end

  // pixel driver
  always @(negedge clk) begin
    if (!push || pix_taken) begin
      if (src_gap > 0) begin
        push <= 1'b0;
        src_gap--;
      end else if (pixels_pending.size() > 0) begin
        next_pix = pixels_pending.pop_front();
        push <= 1'b1;
        red <= next_pix.red;
        green <= next_pix.green;
        blue <= next_pix.blue;
        alpha <= next_pix.alpha;
        src_gap = next_gap(src_burst);
      end else begin
        push <= 1'b0;
      end
    end
  end

  // cell receiver
  always @(negedge clk) begin
    if (hold_request && !hold_served) begin
      // hold off long enough for the block to back up into its input
      pop <= 1'b0;
      hold_count++;
      if (hold_count >= LONG_HOLD) hold_served = 1'b1;
    end else if (!pop || cell_taken) begin
      if (snk_gap > 0) begin
        pop <= 1'b0;
        snk_gap--;
      end else begin
        pop <= 1'b1;
        snk_gap = next_gap(snk_burst);
      end
    end
  end

  task automatic queue_pixel(input int unsigned r, input int unsigned g, input int unsigned b,
                             input int unsigned a);
    pixel_t p;
    p.red = r[CH_W-1:0];
    p.green = g[CH_W-1:0];
    p.blue = b[CH_W-1:0];
    p.alpha = a[CH_W-1:0];
    pixels_pending.push_back(p);
  endtask

  task automatic queue_random(input int unsigned n);
    repeat (n) pixels_pending.push_back(rand_pixel());
  endtask

  task automatic wait_idle(input int unsigned settle);
    while (pixels_pending.size() != 0 || push) @(posedge clk);
    while (cells_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned w, h;
    logic [CFG_DATA_W-1:0] junk;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // one row at reset size: every cell is a single pixel
    queue_pixel(0, 0, 0, 0);
    queue_pixel(255, 255, 255, 255);
    queue_pixel(127, 127, 127, 0);      // mean just below the limit
    queue_pixel(128, 128, 128, 255);    // mean exactly at the limit
    queue_pixel(127, 128, 128, 7);
    queue_pixel(128, 128, 129, 0);
    queue_pixel(255, 0, 128, 170);
    queue_pixel(0, 255, 129, 85);
    queue_pixel(255, 255, 0, 1);
    queue_pixel(0, 0, 255, 254);
    queue_random(OUT_SIDE - 10);
    wait_idle(SETTLE_CYCLES);

    // two more bands under a long receiver hold, then stop inside a row
    hold_request = 1'b1;
    queue_random(OUT_SIDE * 2 + 12);
    wait_idle(SETTLE_CYCLES);

    // write to an unlisted index: the open row must carry on
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_SPARE, junk);
    queue_random(OUT_SIDE - 12 + OUT_SIDE);
    wait_idle(SETTLE_CYCLES);

    // upper data bits are dropped: selects rgba
    write_reg(REG_MODE, 13'h1FFD);
    queue_pixel(10, 20, 30, 0);
    queue_pixel(255, 255, 255, 255);    // product wraps into the low byte
    queue_pixel(128, 128, 128, 1);
    queue_pixel(255, 255, 255, 1);
    queue_pixel(100, 100, 100, 3);
    queue_random(OUT_SIDE);
    wait_idle(SETTLE_CYCLES);

    // sizes below range clamp up to the grid side
    write_reg(REG_WIDTH, CFG_DATA_W'(OUT_SIDE - 1));
    write_reg(REG_HEIGHT, '0);
    write_reg(REG_MODE, CFG_DATA_W'(MODE_ZERO));
    queue_random(OUT_SIDE + 3);
    wait_idle(SETTLE_CYCLES);

    write_reg(REG_WIDTH, CFG_DATA_W'(29));
    write_reg(REG_HEIGHT, CFG_DATA_W'(31));
    write_reg(REG_MODE, CFG_DATA_W'(MODE_SPARE));
    queue_random(29 + 4);
    wait_idle(SETTLE_CYCLES);

    // first band two rows tall, random mode
    w = $urandom_range(OUT_SIDE, OUT_SIDE + 8);
    h = $urandom_range(2 * OUT_SIDE, 3 * OUT_SIDE - 1);
    write_reg(REG_WIDTH, w[CFG_DATA_W-1:0]);
    write_reg(REG_HEIGHT, h[CFG_DATA_W-1:0]);
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_MODE, junk);
    queue_random(w * band_edge(1, h) + $urandom_range(0, w - 1));
    wait_idle(SETTLE_CYCLES);

    wait_idle(TAIL_CYCLES);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT);
    $display("FAIL");
    $finish;
  end

endmodule
